@@ hdl/telemetry_frame_builder_crc8_defines.svh @@
// Assertion macros shared by the frame builder modules.
// The enclosing module must provide clk and rst_n.
`ifndef TELEMETRY_FRAME_BUILDER_CRC8_DEFINES_SVH
`define TELEMETRY_FRAME_BUILDER_CRC8_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TFB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfb assertion failed");

`define TFB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfb assertion failed");

`else

`define TFB_ASSERT_IMP(lbl, ante, cons)

`define TFB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ hdl/tfb_pkg.sv @@
package tfb_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int CMD_DEPTH_DEF       = 4;

    localparam int       APB_ADDR_W       = 3;
    localparam int       APB_DATA_W       = 32;
    localparam logic     CFG_OUT_CAPACITY = 1'b0;
    localparam logic [6:0] OUT_CAPACITY_RST = 7'd64;

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    typedef enum logic [2:0] {
        CMD_REJECT,
        CMD_HDR,
        CMD_HDR_LAST,
        CMD_PAY,
        CMD_PAY_LAST
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] addr;
        logic [7:0] len_byte;
        logic [7:0] ftype;
        logic [7:0] data;
        logic [7:0] crc;
    } cmd_t;

    // CRC-8, polynomial 0xD5, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'd0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

@@ hdl/tfb_front.sv @@
`include "telemetry_frame_builder_crc8_defines.svh"

module tfb_front #(
    parameter int MAX_FRAME_BYTES = tfb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          fifo_full,
    input  logic [6:0]    out_capacity,
    input  logic          func,
    input  logic [7:0]    frame_address,
    input  logic [7:0]    frame_type,
    input  logic [7:0]    payload_length,
    input  logic [7:0]    payload_byte,
    output logic          cmd_wr,
    output tfb_pkg::cmd_t cmd_data
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FRAME = 3'b010,
        PH_DROP  = 3'b100
    } phase_t;

    localparam logic [8:0] MAX_TOTAL = 9'(MAX_FRAME_BYTES);

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] crc_reg, crc_next;

    logic       accept;
    logic [8:0] total;
    logic       reject;
    logic [7:0] crc_type;
    logic [7:0] crc_pay;
    logic [7:0] rem_dec;

    assign accept   = push && !fifo_full;
    assign total    = {1'b0, payload_length} + 9'd4;
    assign reject   = ({2'b00, out_capacity} < total) || (total > MAX_TOTAL);
    assign crc_type = tfb_pkg::crc8_step(8'd0, frame_type);
    assign crc_pay  = tfb_pkg::crc8_step(crc_reg, payload_byte);
    assign rem_dec  = remaining_reg - 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        crc_next          = crc_reg;
        cmd_wr            = 1'b0;
        cmd_data.kind     = tfb_pkg::CMD_PAY;
        cmd_data.addr     = frame_address;
        cmd_data.len_byte = payload_length + 8'd2;
        cmd_data.ftype    = frame_type;
        cmd_data.data     = payload_byte;
        cmd_data.crc      = crc_type;
        if (accept) begin
            if (func == 1'b0) begin
                cmd_wr = 1'b1;
                if (reject) begin
                    cmd_data.kind  = tfb_pkg::CMD_REJECT;
                    crc_next       = 8'd0;
                    remaining_next = payload_length;
                    phase_next     = (payload_length != 8'd0) ? PH_DROP : PH_IDLE;
                end
                else if (payload_length == 8'd0) begin
                    cmd_data.kind  = tfb_pkg::CMD_HDR_LAST;
                    crc_next       = 8'd0;
                    remaining_next = 8'd0;
                    phase_next     = PH_IDLE;
                end
                else begin
                    cmd_data.kind  = tfb_pkg::CMD_HDR;
                    crc_next       = crc_type;
                    remaining_next = payload_length;
                    phase_next     = PH_FRAME;
                end
            end
            else begin
                unique case (phase_reg)
                    PH_FRAME:
                    begin
                        cmd_wr         = 1'b1;
                        cmd_data.crc   = crc_pay;
                        remaining_next = rem_dec;
                        if (rem_dec == 8'd0) begin
                            cmd_data.kind = tfb_pkg::CMD_PAY_LAST;
                            crc_next      = 8'd0;
                            phase_next    = PH_IDLE;
                        end
                        else begin
                            cmd_data.kind = tfb_pkg::CMD_PAY;
                            crc_next      = crc_pay;
                        end
                    end
                    PH_DROP:
                    begin
                        remaining_next = rem_dec;
                        if (rem_dec == 8'd0)
                            phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        // stray payload byte
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 8'd0;
            crc_reg       <= 8'd0;
        end
        else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            crc_reg       <= crc_next;
        end
    end

    `TFB_ASSERT_IMP(a_idle_no_remaining, phase_reg == PH_IDLE, remaining_reg == 8'd0)
    `TFB_ASSERT_IMP(a_busy_has_remaining, phase_reg != PH_IDLE, remaining_reg != 8'd0)

endmodule

@@ hdl/tfb_cmd_fifo.sv @@
`include "telemetry_frame_builder_crc8_defines.svh"

module tfb_cmd_fifo #(
    parameter int DEPTH = tfb_pkg::CMD_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tfb_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output tfb_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfb_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TFB_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

@@ hdl/tfb_back.sv @@
`include "telemetry_frame_builder_crc8_defines.svh"

module tfb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  tfb_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic          frame_end,
    output logic          status
);

    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;
    logic       status_reg;

    logic [1:0] last_step;
    logic       advance;
    logic [7:0] sel_byte;
    logic       sel_end;
    logic       sel_status;

    assign advance = cmd_valid && (!out_valid_reg || pop);
    assign cmd_pop = advance && (step_reg == last_step);

    always_comb
    begin
        unique case (cmd.kind)
            tfb_pkg::CMD_HDR:      last_step = 2'd2;
            tfb_pkg::CMD_HDR_LAST: last_step = 2'd3;
            tfb_pkg::CMD_PAY_LAST: last_step = 2'd1;
            default:               last_step = 2'd0;
        endcase
    end

    always_comb
    begin
        sel_byte   = cmd.data;
        sel_end    = 1'b0;
        sel_status = 1'b0;
        case (cmd.kind)
            tfb_pkg::CMD_REJECT:
            begin
                sel_byte   = 8'd0;
                sel_end    = 1'b1;
                sel_status = 1'b1;
            end
            tfb_pkg::CMD_HDR, tfb_pkg::CMD_HDR_LAST:
            begin
                case (step_reg)
                    2'd0:    sel_byte = cmd.addr;
                    2'd1:    sel_byte = cmd.len_byte;
                    2'd2:    sel_byte = cmd.ftype;
                    default:
                    begin
                        sel_byte = cmd.crc;
                        sel_end  = 1'b1;
                    end
                endcase
            end
            tfb_pkg::CMD_PAY_LAST:
            begin
                if (step_reg != 2'd0) begin
                    sel_byte = cmd.crc;
                    sel_end  = 1'b1;
                end
            end
            default:
            begin
                sel_byte = cmd.data;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            step_next      = cmd_pop ? 2'd0 : step_reg + 2'd1;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_byte_reg  <= sel_byte;
            frame_end_reg <= sel_end;
            status_reg    <= sel_status;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign status    = status_reg;

    `TFB_ASSERT_IMP(a_step_in_range, cmd_valid, step_reg <= last_step)
    `TFB_ASSERT_IMP(a_step_idle_zero, !cmd_valid, step_reg == 2'd0)
    `TFB_ASSERT_NXT(a_held_until_pop, out_valid_reg && !pop, out_valid_reg)

endmodule

@@ hdl/telemetry_frame_builder_crc8.sv @@
// Telemetry frame builder with CRC-8 (poly 0xD5, init 0).
// Input queue side: present an item with push; it transfers when full is low.
//   func 0 = header (frame_address, frame_type, payload_length),
//   func 1 = payload byte. Items that produce no bytes still transfer.
// Result queue side: while empty is low, out_byte/frame_end/status hold the
//   oldest byte; it transfers on pop. A good header yields address, length,
//   type (plus CRC if the payload is empty); each payload byte yields itself,
//   and the last one also the CRC. A rejected header yields one status byte.
// The first byte of an item passes through the command queue and then the output register before it is visible.
// Throughput: one item per cycle is taken while the command queue has room;
//   the back end delivers one byte per cycle while pop keeps up, so an accepted
//   header yields three to four output bytes, a rejected header one, and a
//   payload byte one (two on the last).
// A receiver stall holds the output register; the command queue (CMD_DEPTH
//   entries) then fills and full rises.
// Reset clears the frame state and both queues; out_capacity returns to 64.
// APB: out_capacity at byte address 0, 7 bits, written in the access phase.
module telemetry_frame_builder_crc8 #(
    parameter int MAX_FRAME_BYTES = tfb_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CMD_DEPTH       = tfb_pkg::CMD_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           func,
    input  logic [7:0]                     frame_address,
    input  logic [7:0]                     frame_type,
    input  logic [7:0]                     payload_length,
    input  logic [7:0]                     payload_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     out_byte,
    output logic                           frame_end,
    output logic                           status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tfb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tfb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [6:0]    out_capacity_reg;
    logic          cfg_wr;
    logic          cmd_wr;
    tfb_pkg::cmd_t cmd_wr_data;
    tfb_pkg::cmd_t cmd_rd_data;
    logic          cmd_empty;
    logic          cmd_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tfb_pkg::CFG_OUT_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_capacity_reg <= tfb_pkg::OUT_CAPACITY_RST;
        else if (cfg_wr)
            out_capacity_reg <= pwdata[6:0];
    end

    assign prdata = (paddr[2] == tfb_pkg::CFG_OUT_CAPACITY) ?
                    {{(tfb_pkg::APB_DATA_W - 7){1'b0}}, out_capacity_reg} : '0;

    tfb_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .fifo_full      (full),
        .out_capacity   (out_capacity_reg),
        .func           (func),
        .frame_address  (frame_address),
        .frame_type     (frame_type),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .cmd_wr         (cmd_wr),
        .cmd_data       (cmd_wr_data)
    );

    tfb_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_wr_data),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    tfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_rd_data),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .status    (status)
    );

endmodule
